// ===== rtl/core/block_buffer_cache_lru_defines.svh =====
// Assertion helpers for the buffer cache slot manager
`ifndef BLOCK_BUFFER_CACHE_LRU_DEFINES_SVH
`define BLOCK_BUFFER_CACHE_LRU_DEFINES_SVH

// Condition implies consequence in the same cycle
`define BBC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bbc assertion failed");

// Condition implies consequence in the next cycle
`define BBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bbc assertion failed");

`endif

// ===== rtl/core/bbc_pkg.sv =====
package bbc_pkg;

  // Slot count and derived widths
  localparam int NSLOTS  = 32;
  localparam int IDX_W   = $clog2(NSLOTS);
  localparam int RANK_W  = IDX_W;
  localparam int SLOT_FW = 5;   // width of the slot fields on the ports
  localparam int DEV_W   = 8;
  localparam int BLK_W   = 32;

  typedef enum logic [1:0] {
    MODE_ACQUIRE = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_DIRTY   = 2'd2,
    MODE_IO      = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_HIT     = 3'd0,
    ST_MISS    = 3'd1,
    ST_BUSY    = 3'd2,
    ST_NONE    = 3'd3,
    ST_NOTBUSY = 3'd4,
    ST_DONE    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_REL_RANK,
    S_REL_SWEEP,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [DEV_W-1:0] dev;
    logic [BLK_W-1:0] blk;
  } tag_t;

  // Result of the shared compare unit for one slot
  typedef struct packed {
    logic match;   // slot tag equals the key
    logic lt;      // slot rank below the low reference
    logic gt;      // slot rank above the high reference
  } cmp_res_t;

endpackage

// ===== rtl/core/bbc_tag_ram.sv =====
// Tag store: one write port, one registered read port
module bbc_tag_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [bbc_pkg::IDX_W-1:0]  waddr,
  input  bbc_pkg::tag_t              wdata,
  input  logic [bbc_pkg::IDX_W-1:0]  raddr,
  output bbc_pkg::tag_t              rdata
);

  bbc_pkg::tag_t mem [bbc_pkg::NSLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/bbc_cmp_unit.sv =====
// Shared compare unit: tag equality and rank ordering for one slot a cycle
module bbc_cmp_unit (
  input  bbc_pkg::tag_t               tag_rd,
  input  logic                        tag_written,
  input  bbc_pkg::tag_t               key,
  input  logic [bbc_pkg::RANK_W-1:0]  rank,
  input  logic [bbc_pkg::RANK_W-1:0]  ref_lo,
  input  logic [bbc_pkg::RANK_W-1:0]  ref_hi,
  output bbc_pkg::cmp_res_t           res
);

  // Unwritten entries hold the reset tag of all zeros
  always_comb begin
    res.match = tag_written ? (tag_rd == key) : (key == '0);
    res.lt    = (rank < ref_lo);
    res.gt    = (rank > ref_hi);
  end

endmodule

// ===== rtl/core/block_buffer_cache_lru.sv =====
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  mode, device, block_number, slot, io_failed
// out      output     out_valid/out_stall status, slot_out, data_valid
//
// Acquire: accept, then one slot per cycle through the tag RAM read port and
//   compare unit, then a flush state (S_SCAN_END) and the finish state.
// Release: rank read, rank sweep over all slots, finish; a slot that is not
//   busy skips the sweep. Mark dirty and io completion go straight to finish.
// Reset is synchronous; tags read as zero until first written, no clearing pass.
// A result waiting on out_stall holds the sequencer in its finish cycle.
`include "block_buffer_cache_lru_defines.svh"

module block_buffer_cache_lru (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_device,
  input  logic [31:0] in_block_number,
  input  logic [4:0]  in_slot,
  input  logic        in_io_failed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [4:0]  out_slot_out,
  output logic        out_data_valid
);

  localparam int IDX_W  = bbc_pkg::IDX_W;
  localparam int RANK_W = bbc_pkg::RANK_W;
  localparam int FW     = bbc_pkg::SLOT_FW;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(bbc_pkg::NSLOTS - 1);

  bbc_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  // Latched transaction
  bbc_pkg::mode_t   mode_r;
  bbc_pkg::tag_t    key_r;
  logic [FW-1:0]    slot_r;
  logic             failed_r;

  // Slot state
  logic [bbc_pkg::NSLOTS-1:0] busy_r, dirty_r, valid_r, tag_wr_r;
  logic [RANK_W-1:0]          rank_r [bbc_pkg::NSLOTS];

  // Scan pipeline and candidates
  logic              cmp_v_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic              found_v_r, vic_v_r;
  logic [IDX_W-1:0]  found_r, vic_r;
  logic [RANK_W-1:0] found_rank_r, vic_rank_r, rel_rank_r;

  // Output register
  logic            out_valid_r;
  bbc_pkg::status_t out_status_r;
  logic [FW-1:0]   out_slot_r;
  logic            out_dv_r;

  logic              accept, out_free, fin_load;
  logic              slot_oor;
  logic [IDX_W-1:0]  slot_idx;
  logic [IDX_W-1:0]  rank_rd_idx;
  logic [RANK_W-1:0] rank_cur, ref_lo;
  bbc_pkg::tag_t     tag_rd;
  bbc_pkg::cmp_res_t cres;
  logic              cand_hit, cand_vic;

  // Finish-cycle decisions
  bbc_pkg::status_t res_status;
  logic [FW-1:0]    res_slot;
  logic             res_dv;
  logic [IDX_W-1:0] upd_idx;
  logic             set_busy, clr_busy, set_dirty, clr_dirty, set_valid, clr_valid, tag_we;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != bbc_pkg::S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign fin_load  = (state_r == bbc_pkg::S_FIN) && out_free;
  assign slot_oor  = ({1'b0, slot_r} >= (FW+1)'(bbc_pkg::NSLOTS));
  assign slot_idx  = slot_r[IDX_W-1:0];

  // Single rank read port, steered by the sequencer
  always_comb begin
    case (state_r)
      bbc_pkg::S_REL_RANK:  rank_rd_idx = slot_idx;
      bbc_pkg::S_REL_SWEEP: rank_rd_idx = idx_r;
      default:              rank_rd_idx = cmp_idx_r;
    endcase
  end
  assign rank_cur = rank_r[rank_rd_idx];
  assign ref_lo   = (state_r == bbc_pkg::S_REL_SWEEP) ? rel_rank_r : found_rank_r;

  bbc_tag_ram u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (vic_r),
    .wdata (key_r),
    .raddr (idx_r),
    .rdata (tag_rd)
  );

  bbc_cmp_unit u_cmp (
    .tag_rd      (tag_rd),
    .tag_written (tag_wr_r[cmp_idx_r]),
    .key         (key_r),
    .rank        (rank_cur),
    .ref_lo      (ref_lo),
    .ref_hi      (vic_rank_r),
    .res         (cres)
  );

  // Candidate updates during the scan
  assign cand_hit = cmp_v_r && cres.match && (!found_v_r || cres.lt);
  assign cand_vic = cmp_v_r && !busy_r[cmp_idx_r] && !dirty_r[cmp_idx_r]
                    && (!vic_v_r || cres.gt);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      bbc_pkg::S_IDLE: begin
        idx_nxt = '0;
        if (accept) begin
          unique case (bbc_pkg::mode_t'(in_mode))
            bbc_pkg::MODE_ACQUIRE: state_nxt = bbc_pkg::S_SCAN;
            bbc_pkg::MODE_RELEASE: state_nxt = bbc_pkg::S_REL_RANK;
            default:               state_nxt = bbc_pkg::S_FIN;
          endcase
        end
      end
      bbc_pkg::S_SCAN: begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = bbc_pkg::S_SCAN_END;
        end
      end
      bbc_pkg::S_SCAN_END: state_nxt = bbc_pkg::S_FIN;
      bbc_pkg::S_REL_RANK: begin
        idx_nxt = '0;
        if (slot_oor || !busy_r[slot_idx]) begin
          state_nxt = bbc_pkg::S_FIN;
        end else begin
          state_nxt = bbc_pkg::S_REL_SWEEP;
        end
      end
      bbc_pkg::S_REL_SWEEP: begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = bbc_pkg::S_FIN;
        end
      end
      bbc_pkg::S_FIN: begin
        if (out_free) begin
          state_nxt = bbc_pkg::S_IDLE;
        end
      end
      default: state_nxt = bbc_pkg::S_IDLE;
    endcase
  end

  // Result and flag updates of the finish cycle
  always_comb begin
    res_status = bbc_pkg::ST_DONE;
    res_slot   = slot_r;
    res_dv     = 1'b0;
    upd_idx    = slot_idx;
    set_busy   = 1'b0;
    clr_busy   = 1'b0;
    set_dirty  = 1'b0;
    clr_dirty  = 1'b0;
    set_valid  = 1'b0;
    clr_valid  = 1'b0;
    tag_we     = 1'b0;
    if (mode_r == bbc_pkg::MODE_ACQUIRE) begin
      if (found_v_r) begin
        upd_idx  = found_r;
        res_slot = FW'(found_r);
        res_dv   = valid_r[found_r];
        if (busy_r[found_r]) begin
          res_status = bbc_pkg::ST_BUSY;
        end else begin
          res_status = bbc_pkg::ST_HIT;
          set_busy   = fin_load;
        end
      end else if (vic_v_r) begin
        upd_idx    = vic_r;
        res_slot   = FW'(vic_r);
        res_status = bbc_pkg::ST_MISS;
        set_busy   = fin_load;
        clr_dirty  = fin_load;
        clr_valid  = fin_load;
        tag_we     = fin_load;
      end else begin
        res_status = bbc_pkg::ST_NONE;
        res_slot   = '0;
      end
    end else if (slot_oor) begin
      res_status = bbc_pkg::ST_NOTBUSY;
    end else if (mode_r == bbc_pkg::MODE_IO) begin
      res_dv = failed_r ? valid_r[slot_idx] : 1'b1;
      if (!failed_r) begin
        set_valid = fin_load;
        clr_dirty = fin_load;
      end
    end else begin
      res_dv = valid_r[slot_idx];
      if (!busy_r[slot_idx]) begin
        res_status = bbc_pkg::ST_NOTBUSY;
      end else if (mode_r == bbc_pkg::MODE_RELEASE) begin
        clr_busy = fin_load;
      end else begin
        set_dirty = fin_load;
      end
    end
  end

  // Control and slot state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bbc_pkg::S_IDLE;
      idx_r       <= '0;
      cmp_v_r     <= 1'b0;
      found_v_r   <= 1'b0;
      vic_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
      busy_r      <= '0;
      dirty_r     <= '0;
      valid_r     <= '0;
      tag_wr_r    <= '0;
      for (int i = 0; i < bbc_pkg::NSLOTS; i++) begin
        rank_r[i] <= RANK_W'(bbc_pkg::NSLOTS - 1 - i);
      end
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cmp_v_r <= (state_r == bbc_pkg::S_SCAN);

      if (accept) begin
        found_v_r <= 1'b0;
        vic_v_r   <= 1'b0;
      end else begin
        if (cand_hit) found_v_r <= 1'b1;
        if (cand_vic) vic_v_r <= 1'b1;
      end

      // Rank sweep: ranks below the released one age by one, released goes to 0
      if (state_r == bbc_pkg::S_REL_SWEEP) begin
        if (idx_r == slot_idx) begin
          rank_r[idx_r] <= '0;
        end else if (cres.lt) begin
          rank_r[idx_r] <= rank_cur + 1'b1;
        end
      end

      if (set_busy)  busy_r[upd_idx]  <= 1'b1;
      if (clr_busy)  busy_r[upd_idx]  <= 1'b0;
      if (set_dirty) dirty_r[upd_idx] <= 1'b1;
      if (clr_dirty) dirty_r[upd_idx] <= 1'b0;
      if (set_valid) valid_r[upd_idx] <= 1'b1;
      if (clr_valid) valid_r[upd_idx] <= 1'b0;
      if (tag_we)    tag_wr_r[vic_r]  <= 1'b1;

      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmp_idx_r <= idx_r;
    if (accept) begin
      mode_r    <= bbc_pkg::mode_t'(in_mode);
      key_r.dev <= in_device;
      key_r.blk <= in_block_number;
      slot_r    <= in_slot;
      failed_r  <= in_io_failed;
    end
    if (cand_hit) begin
      found_r      <= cmp_idx_r;
      found_rank_r <= rank_cur;
    end
    if (cand_vic) begin
      vic_r      <= cmp_idx_r;
      vic_rank_r <= rank_cur;
    end
    if (state_r == bbc_pkg::S_REL_RANK) begin
      rel_rank_r <= rank_cur;
    end
    if (fin_load) begin
      out_status_r <= res_status;
      out_slot_r   <= res_slot;
      out_dv_r     <= res_dv;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_out   = out_slot_r;
  assign out_data_valid = out_dv_r;

  // A recycled slot is busy once the miss is reported
  `BBC_ASSERT_NEXT(a_miss_busy, fin_load && res_status == bbc_pkg::ST_MISS, busy_r[$past(vic_r)])
  // A new result only appears out of the finish cycle
  `BBC_ASSERT_SAME(a_out_from_fin, $rose(out_valid_r), $past(state_r) == bbc_pkg::S_FIN)
  // The released slot becomes most recent at the end of the sweep
  `BBC_ASSERT_NEXT(a_rel_rank0, state_r == bbc_pkg::S_REL_SWEEP && idx_r == LAST_IDX, rank_r[slot_idx] == '0)

endmodule
